### src/cblm_pkg.sv
// Shared types, constants and helper functions for the CAN bus load meter.
// Used by the datapath, the controller, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cblm_pkg;

   localparam int BUS_COUNT = 2;
   localparam int BUS_IDX_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
   localparam int SEL_W     = BUS_IDX_W + 1;
   localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(2 * BUS_COUNT - 1);

   localparam int BUS_A = 0;
   localparam int BUS_B = 1;

   localparam int DATA_W = 32;
   localparam int PCT_W  = 7;
   localparam int RATE_W = 20;
   localparam int WIRE_W = 8;

   localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(500000);
   localparam logic [PCT_W-1:0]  PCT_MAX      = PCT_W'(100);
   localparam logic [DATA_W-1:0] PCT_SCALE    = DATA_W'(100);

   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      MODE_RX        = 3'd0,
      MODE_TX        = 3'd1,
      MODE_ROLL      = 3'd2,
      MODE_READ      = 3'd3,
      MODE_SET_DROP  = 3'd4,
      MODE_SET_FAIL  = 3'd5,
      MODE_BUMP_DROP = 3'd6
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_LOAD  = 5'b00100,
      S_DIV   = 5'b01000,
      S_STORE = 5'b10000
   } state_type;

   typedef struct packed {
      logic             latch;
      logic             apply;
      logic             snap;
      logic             div_start;
      logic             store_pct;
      logic             load_rsp;
      logic [SEL_W-1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       div_done;
      logic       rsp_free;
   } status_type;

   // Worst-case on-wire bits of one frame, including stuff bits.
   function automatic logic [WIRE_W-1:0] wire_bits(input logic [3:0] dlc,
                                                   input logic       ext);
      logic [3:0]        d;
      logic [WIRE_W-1:0] pay;
      logic [WIRE_W-1:0] stuff;
      d   = (dlc > 4'd8) ? 4'd8 : dlc;
      pay = {1'b0, d, 3'b000};
      if (ext) begin
         stuff = (WIRE_W'(53) + pay) >> 2;
         return WIRE_W'(67) + pay + stuff;
      end
      stuff = (WIRE_W'(33) + pay) >> 2;
      return WIRE_W'(47) + pay + stuff;
   endfunction

endpackage

`default_nettype wire

### src/cblm_divider.sv
// Serial restoring divider, one quotient bit per clock.
// Depends on cblm_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module cblm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [cblm_pkg::DATA_W-1:0]   dividend,
   input  wire logic [cblm_pkg::RATE_W-1:0]   divisor,
   output logic                               done,
   output logic      [cblm_pkg::DATA_W-1:0]   quotient
);
   import cblm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [RATE_W-1:0]    dvs_ff, dvs_in;
   logic [RATE_W:0]      trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? RATE_W'(trial - {1'b0, dvs_ff}) : RATE_W'(trial);
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### src/cblm_datapath.sv
// Datapath: item register, per-bus accumulators, window and counter stores,
// rate register, percent divider and response register. Uses cblm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cblm_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cblm_pkg::cmd_type            cmd,
   output cblm_pkg::status_type              status,
   input  wire logic [3:0]                   req_tuser,
   input  wire logic [39:0]                  req_tdata,
   input  wire logic                         csr_valid,
   input  wire logic [cblm_pkg::RATE_W-1:0]  csr_data,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [207:0]                 rsp_tdata
);
   import cblm_pkg::*;

   logic [2:0]        mode_ff;
   logic              bus_ff;
   logic [3:0]        dlc_ff;
   logic              ext_ff;
   logic [DATA_W-1:0] value_ff;
   logic              ov0_ff;
   logic              ov1_ff;

   logic [RATE_W-1:0] rate_ff;

   logic [DATA_W-1:0] rx_bit_acc_ff     [BUS_COUNT];
   logic [DATA_W-1:0] tx_bit_acc_ff     [BUS_COUNT];
   logic [DATA_W-1:0] rx_frame_acc_ff   [BUS_COUNT];
   logic [DATA_W-1:0] tx_frame_acc_ff   [BUS_COUNT];
   logic [DATA_W-1:0] rx_bits_win_ff    [BUS_COUNT];
   logic [DATA_W-1:0] tx_bits_win_ff    [BUS_COUNT];
   logic [DATA_W-1:0] rx_fcnt_win_ff    [BUS_COUNT];
   logic [DATA_W-1:0] tx_fcnt_win_ff    [BUS_COUNT];
   logic [PCT_W-1:0]  rx_pct_win_ff     [BUS_COUNT];
   logic [PCT_W-1:0]  tx_pct_win_ff     [BUS_COUNT];
   logic [DATA_W-1:0] drop_count_ff     [BUS_COUNT];
   logic [DATA_W-1:0] fail_count_ff     [BUS_COUNT];

   logic              rsp_valid_ff;
   logic [207:0]      rsp_data_ff;

   logic [BUS_IDX_W-1:0] bus_idx;
   logic                 bus_ok;
   logic [DATA_W-1:0]    frame_bits;
   logic [RATE_W-1:0]    rate_eff;
   logic [BUS_IDX_W-1:0] div_bus;
   logic                 div_tx;
   logic [DATA_W-1:0]    div_bits;
   logic [DATA_W-1:0]    dividend;
   logic                 div_done;
   logic [DATA_W-1:0]    quotient;
   logic [PCT_W-1:0]     pct;
   logic                 rsp_free;

   assign bus_idx    = BUS_IDX_W'(bus_ff);
   assign bus_ok     = 32'(bus_ff) < 32'(BUS_COUNT);
   assign frame_bits = DATA_W'(wire_bits(dlc_ff, ext_ff));
   assign rate_eff   = (rate_ff == '0) ? DEFAULT_RATE : rate_ff;
   assign div_bus    = cmd.sel[SEL_W-1:1];
   assign div_tx     = cmd.sel[0];
   assign div_bits   = div_tx ? tx_bits_win_ff[div_bus] : rx_bits_win_ff[div_bus];
   assign dividend   = div_bits * PCT_SCALE + DATA_W'(rate_eff >> 1);
   assign pct        = (quotient > DATA_W'(PCT_MAX)) ? PCT_MAX : quotient[PCT_W-1:0];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   cblm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (rate_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= req_tuser[2:0];
         bus_ff   <= req_tuser[3];
         dlc_ff   <= req_tdata[3:0];
         ext_ff   <= req_tdata[4];
         value_ff <= req_tdata[36:5];
         ov0_ff   <= req_tdata[37];
         ov1_ff   <= req_tdata[38];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= DEFAULT_RATE;
      end else if (csr_valid) begin
         rate_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUS_COUNT; i++) begin
            rx_bit_acc_ff[i]    <= '0;
            tx_bit_acc_ff[i]    <= '0;
            rx_frame_acc_ff[i]  <= '0;
            tx_frame_acc_ff[i]  <= '0;
            rx_bits_win_ff[i]   <= '0;
            tx_bits_win_ff[i]   <= '0;
            rx_fcnt_win_ff[i]   <= '0;
            tx_fcnt_win_ff[i]   <= '0;
            rx_pct_win_ff[i]    <= '0;
            tx_pct_win_ff[i]    <= '0;
            drop_count_ff[i]    <= '0;
            fail_count_ff[i]    <= '0;
         end
      end else begin
         if (cmd.apply) begin
            unique case (mode_ff)
               MODE_RX: begin
                  if (bus_ok) begin
                     rx_bit_acc_ff[bus_idx]   <= rx_bit_acc_ff[bus_idx] + frame_bits;
                     rx_frame_acc_ff[bus_idx] <= rx_frame_acc_ff[bus_idx] + DATA_W'(1);
                  end
               end
               MODE_TX: begin
                  if (bus_ok) begin
                     tx_bit_acc_ff[bus_idx]   <= tx_bit_acc_ff[bus_idx] + frame_bits;
                     tx_frame_acc_ff[bus_idx] <= tx_frame_acc_ff[bus_idx] + DATA_W'(1);
                  end
               end
               MODE_SET_DROP: begin
                  if (BUS_A < BUS_COUNT) begin
                     drop_count_ff[BUS_IDX_W'(BUS_A)] <= value_ff;
                  end
               end
               MODE_SET_FAIL: begin
                  if (BUS_A < BUS_COUNT) begin
                     fail_count_ff[BUS_IDX_W'(BUS_A)] <= value_ff;
                  end
               end
               MODE_BUMP_DROP: begin
                  if (BUS_B < BUS_COUNT) begin
                     drop_count_ff[BUS_IDX_W'(BUS_B)] <= drop_count_ff[BUS_IDX_W'(BUS_B)]
                        + DATA_W'(ov0_ff) + DATA_W'(ov1_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.snap) begin
            for (int i = 0; i < BUS_COUNT; i++) begin
               rx_bits_win_ff[i]   <= rx_bit_acc_ff[i];
               tx_bits_win_ff[i]   <= tx_bit_acc_ff[i];
               rx_fcnt_win_ff[i]   <= rx_frame_acc_ff[i];
               tx_fcnt_win_ff[i]   <= tx_frame_acc_ff[i];
               rx_bit_acc_ff[i]    <= '0;
               tx_bit_acc_ff[i]    <= '0;
               rx_frame_acc_ff[i]  <= '0;
               tx_frame_acc_ff[i]  <= '0;
            end
         end
         if (cmd.store_pct) begin
            if (div_tx) begin
               tx_pct_win_ff[div_bus] <= pct;
            end else begin
               rx_pct_win_ff[div_bus] <= pct;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (bus_ok) begin
            rsp_data_ff <= {2'b00,
                            fail_count_ff[bus_idx],
                            drop_count_ff[bus_idx],
                            tx_fcnt_win_ff[bus_idx],
                            rx_fcnt_win_ff[bus_idx],
                            tx_bits_win_ff[bus_idx],
                            rx_bits_win_ff[bus_idx],
                            tx_pct_win_ff[bus_idx],
                            rx_pct_win_ff[bus_idx]};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign status.mode     = mode_ff;
   assign status.div_done = div_done;
   assign status.rsp_free = rsp_free;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

`default_nettype wire

### src/cblm_ctrl.sv
// Controller state machine: sequences item execution and the window roll.
// Talks to cblm_datapath only through cblm_pkg command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module cblm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire cblm_pkg::status_type  status,
   output cblm_pkg::cmd_type          cmd
);
   import cblm_pkg::*;

   state_type        state_ff, state_in;
   logic [SEL_W-1:0] sel_ff, sel_in;

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      cmd           = '0;
      cmd.sel       = sel_ff;
      req_tready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (status.mode == MODE_READ) begin
               if (status.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (status.mode == MODE_ROLL) begin
               cmd.snap = 1'b1;
               sel_in   = '0;
               state_in = S_LOAD;
            end else begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store_pct = 1'b1;
            if (sel_ff == SEL_LAST) begin
               state_in = S_IDLE;
            end else begin
               sel_in   = sel_ff + SEL_W'(1);
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

`default_nettype wire

### src/can_bus_load_meter.sv
// Top level of the CAN bus load meter: joins the controller and the datapath.
// Depends on cblm_pkg, cblm_ctrl, cblm_datapath and cblm_divider.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken at a time. Each word is captured on acceptance and then
// executed; a read is loaded into the response register once that register is
// free, waits there until it is taken, and the next word is accepted while it
// waits. A roll-window word snapshots the windows and then, for each bus and
// direction, runs the serial restoring divider, which computes each rounded
// percentage one quotient bit per cycle. A rate of zero is used as 500000 bps.
module can_bus_load_meter (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [3:0]    req_tuser,  // mode[2:0], bus[3]
   input  wire logic [39:0]   req_tdata,  // dlc, ext_id, value, overflow_fifo0,
                                          // overflow_fifo1, zero pad
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic      [207:0]  rsp_tdata,  // rx_pct, tx_pct, rx_bits, tx_bits,
                                          // rx_frame_cnt, tx_frame_cnt, rx_drops,
                                          // tx_failures, zero pad
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [19:0]   csr_data
);
   import cblm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cblm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cblm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("response register loaded while a word is still pending");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while the previous word is executing");

   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider done flag not cleared on start");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_rsp))
      else $error("response valid raised without a read");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for can_bus_load_meter: sends frame, roll, read and counter
// words under several bit rates and checks every read word against a scoreboard
// that tracks the meter's accumulators and windows. Depends on cblm_pkg and can_bus_load_meter.

module testbench;
   import cblm_pkg::*;

   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 178;
   localparam int PHASE_COUNT   = 6;

   typedef struct packed {
      logic        pad;
      logic        ovf1;
      logic        ovf0;
      logic [31:0] value;
      logic        ext;
      logic [3:0]  dlc;
   } frame_word_t;

   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] tx_failures, rx_drops, tx_frame_cnt, rx_frame_cnt, tx_bits, rx_bits;
      logic [6:0]  tx_pct, rx_pct;
   } load_reading_t;

   class load_meter_scoreboard;
      logic [RATE_W-1:0] rate;
      logic [31:0]       rx_bit_acc[BUS_COUNT], tx_bit_acc[BUS_COUNT];
      logic [31:0]       rx_frame_acc[BUS_COUNT], tx_frame_acc[BUS_COUNT];
      logic [31:0]       drop_count[BUS_COUNT], fail_count[BUS_COUNT];
      load_reading_t     last_window[BUS_COUNT];
      load_reading_t     pending_readings[$];
      int                errors;
      int                readings_checked;
      int                rolls;

      function new();
         rate = DEFAULT_RATE;
         errors = 0;
         readings_checked = 0;
         rolls = 0;
         for (int i = 0; i < BUS_COUNT; i++) begin
            rx_bit_acc[i] = '0;
            tx_bit_acc[i] = '0;
            rx_frame_acc[i] = '0;
            tx_frame_acc[i] = '0;
            drop_count[i] = '0;
            fail_count[i] = '0;
            last_window[i] = '0;
         end
      endfunction

      // Worst-case frame length on the wire, stuff bits included.
      function logic [31:0] frame_wire_bits(logic [3:0] dlc, logic ext);
         logic [31:0] payload;
         payload = (dlc > 4'd8) ? 32'd64 : {25'd0, dlc, 3'b000};
         if (ext) begin
            return 32'd67 + payload + (32'd53 + payload) / 32'd4;
         end
         return 32'd47 + payload + (32'd33 + payload) / 32'd4;
      endfunction

      // Rounded utilization, every step wrapping at 32 bits, capped at 100.
      function logic [6:0] window_percent(logic [31:0] bits);
         logic [31:0] eff_rate;
         logic [31:0] scaled;
         logic [31:0] quotient;
         eff_rate = (rate == '0) ? 32'(DEFAULT_RATE) : 32'(rate);
         scaled = bits * 32'd100;
         scaled = scaled + (eff_rate >> 1);
         quotient = scaled / eff_rate;
         return (quotient > 32'd100) ? 7'd100 : quotient[6:0];
      endfunction

      function void note_word(logic [2:0] mode, logic bus, frame_word_t w);
         load_reading_t reading;
         case (mode)
            MODE_RX: begin
               rx_bit_acc[bus] += frame_wire_bits(w.dlc, w.ext);
               rx_frame_acc[bus] += 32'd1;
            end
            MODE_TX: begin
               tx_bit_acc[bus] += frame_wire_bits(w.dlc, w.ext);
               tx_frame_acc[bus] += 32'd1;
            end
            MODE_ROLL: begin
               rolls++;
               for (int i = 0; i < BUS_COUNT; i++) begin
                  last_window[i].rx_bits = rx_bit_acc[i];
                  last_window[i].tx_bits = tx_bit_acc[i];
                  last_window[i].rx_frame_cnt = rx_frame_acc[i];
                  last_window[i].tx_frame_cnt = tx_frame_acc[i];
                  last_window[i].rx_pct = window_percent(rx_bit_acc[i]);
                  last_window[i].tx_pct = window_percent(tx_bit_acc[i]);
                  rx_bit_acc[i] = '0;
                  tx_bit_acc[i] = '0;
                  rx_frame_acc[i] = '0;
                  tx_frame_acc[i] = '0;
               end
            end
            MODE_READ: begin
               reading = last_window[bus];
               reading.rx_drops = drop_count[bus];
               reading.tx_failures = fail_count[bus];
               reading.pad = '0;
               pending_readings.push_back(reading);
            end
            MODE_SET_DROP: drop_count[BUS_A] = w.value;
            MODE_SET_FAIL: fail_count[BUS_A] = w.value;
            MODE_BUMP_DROP: drop_count[BUS_B] += 32'(w.ovf0) + 32'(w.ovf1);
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_reading(load_reading_t got);
         load_reading_t want;
         if (pending_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected read word, expected none, actual %h", $time, got);
            return;
         end
         want = pending_readings.pop_front();
         readings_checked++;
         compare_field("rx_pct", 32'(want.rx_pct), 32'(got.rx_pct));
         compare_field("tx_pct", 32'(want.tx_pct), 32'(got.tx_pct));
         compare_field("rx_bits", want.rx_bits, got.rx_bits);
         compare_field("tx_bits", want.tx_bits, got.tx_bits);
         compare_field("rx_frame_cnt", want.rx_frame_cnt, got.rx_frame_cnt);
         compare_field("tx_frame_cnt", want.tx_frame_cnt, got.tx_frame_cnt);
         compare_field("rx_drops", want.rx_drops, got.rx_drops);
         compare_field("tx_failures", want.tx_failures, got.tx_failures);
         compare_field("pad", 32'(want.pad), 32'(got.pad));
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [3:0]    req_tuser = '0;
   logic [39:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [207:0]  rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [19:0]   csr_data = '0;

   load_meter_scoreboard meter = new();
   bit  calm = 1'b0;
   bit  hold_phase = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_left = 0;
   int  cycles = 0;
   int  words_sent = 0;
   int  rate_writes = 0;

   can_bus_load_meter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: checks each accepted word, then picks the next ready level.
   // One long hold-off lets the block fill up and stall its input.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            meter.check_reading(load_reading_t'(rsp_tdata));
         end
         if (hold_phase && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 15);
         end
      end
   end

   function automatic frame_word_t make_word(logic [3:0] dlc, logic ext, logic [31:0] value,
                                             logic ovf0, logic ovf1);
      frame_word_t w;
      w.pad = 1'b0;
      w.ovf1 = ovf1;
      w.ovf0 = ovf0;
      w.value = value;
      w.ext = ext;
      w.dlc = dlc;
      return w;
   endfunction

   task automatic send_word(input logic [2:0] mode, input logic bus, input frame_word_t w);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {bus, mode};
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      meter.note_word(mode, bus, w);
      words_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (meter.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input logic [19:0] rate);
      csr_valid <= 1'b1;
      csr_data <= rate;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      meter.rate = rate;
      rate_writes++;
   endtask

   task automatic send_random_word(output logic [2:0] mode);
      int          pick;
      logic [31:0] value;
      logic [3:0]  dlc;
      pick = $urandom_range(99);
      if (pick < 28)      mode = MODE_RX;
      else if (pick < 56) mode = MODE_TX;
      else if (pick < 62) mode = MODE_ROLL;
      else if (pick < 80) mode = MODE_READ;
      else if (pick < 85) mode = MODE_SET_DROP;
      else if (pick < 90) mode = MODE_SET_FAIL;
      else if (pick < 96) mode = MODE_BUMP_DROP;
      else                mode = MODE_UNUSED;
      case ($urandom_range(7))
         0: value = '0;
         1: value = '1;
         default: value = $urandom;
      endcase
      dlc = $urandom_range(1) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
      send_word(mode, 1'($urandom_range(1)),
                make_word(dlc, 1'($urandom_range(1)), value,
                          1'($urandom_range(1)), 1'($urandom_range(1))));
   endtask

   initial begin
      logic [2:0]  mode;
      logic [19:0] rate;
      int          counted;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset bit rate.
      send_word(MODE_READ, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_READ, 1'b1, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_RX, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_RX, 1'b0, make_word(4'd8, 1'b1, '0, 1'b0, 1'b0));
      send_word(MODE_RX, 1'b1, make_word(4'd15, 1'b0, '1, 1'b1, 1'b1));
      send_word(MODE_RX, 1'b1, make_word(4'd9, 1'b1, '0, 1'b0, 1'b0));
      send_word(MODE_TX, 1'b0, make_word(4'd8, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_TX, 1'b1, make_word(4'd0, 1'b1, '0, 1'b0, 1'b0));
      send_word(MODE_TX, 1'b0, make_word(4'd4, 1'b1, '0, 1'b0, 1'b0));
      send_word(MODE_SET_DROP, 1'b0, make_word(4'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0));
      send_word(MODE_SET_FAIL, 1'b1, make_word(4'd0, 1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0));
      send_word(MODE_BUMP_DROP, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_BUMP_DROP, 1'b1, make_word(4'd0, 1'b0, '0, 1'b1, 1'b0));
      send_word(MODE_BUMP_DROP, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b1));
      send_word(MODE_BUMP_DROP, 1'b1, make_word(4'd0, 1'b0, '0, 1'b1, 1'b1));
      send_word(MODE_UNUSED, 1'b1, make_word(4'hF, 1'b1, '1, 1'b1, 1'b1));
      send_word(MODE_READ, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_ROLL, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_READ, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_READ, 1'b1, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_ROLL, 1'b1, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      send_word(MODE_READ, 1'b1, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
      settle();

      // Random phases, each under its own bit rate, with zero and both ends of
      // the range among them.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: rate = 20'd0;
            1: rate = 20'd1;
            2: rate = 20'd1000000;
            3: rate = 20'd700;
            4: rate = 20'($urandom_range(5000, 300));
            default: rate = 20'($urandom_range(1000000, 1));
         endcase
         write_rate(rate);
         calm = (phase == 2);
         hold_phase = (phase == 3);
         counted = 0;
         while (counted < PHASE_WORDS) begin
            send_random_word(mode);
            if (mode != MODE_UNUSED) begin
               counted++;
            end
         end
         send_word(MODE_ROLL, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
         send_word(MODE_READ, 1'b0, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
         send_word(MODE_READ, 1'b1, make_word(4'd0, 1'b0, '0, 1'b0, 1'b0));
         settle();
      end

      $display("Sent %0d words under %0d bit-rate settings, %0d of them window rolls.",
               words_sent, rate_writes + 1, meter.rolls);
      $display("Checked %0d read words field by field, %0d mismatches.",
               meter.readings_checked, meter.errors);
      if (meter.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
src/cblm_pkg.sv
src/cblm_divider.sv
src/cblm_datapath.sv
src/cblm_ctrl.sv
src/can_bus_load_meter.sv
tb/sv/testbench.sv
